[rtl/utf8_decoder_validator_unit_assert.svh]
// ----------------------------------------------------------------------------
// utf8 decoder assertion macros
// shared property forms for the decoder rtl
// ----------------------------------------------------------------------------
`ifndef UTF8_DECODER_VALIDATOR_UNIT_ASSERT_SVH
`define UTF8_DECODER_VALIDATOR_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define UDV_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("utf8 decoder assertion failed");

// next-cycle implication, disabled in reset
`define UDV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("utf8 decoder assertion failed");

`endif

[rtl/utf8dv_pkg.sv]
// ----------------------------------------------------------------------------
// utf8dv_pkg
// shared types and constants of the utf8 decoder and validator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package utf8dv_pkg;

   // output form codes
   localparam logic [1:0] FORM_UTF16 = 2'd0;
   localparam logic [1:0] FORM_UTF32 = 2'd1;
   localparam logic [1:0] FORM_CHECK = 2'd2;

   // byte boundaries
   localparam logic [7:0] BYTE_ASCII_END = 8'd128;
   localparam logic [7:0] BYTE_CONT_LAST = 8'd191;
   localparam logic [7:0] BYTE_LEAD2_MIN = 8'd194;
   localparam logic [7:0] BYTE_LEAD3_MIN = 8'd224;
   localparam logic [7:0] BYTE_LEAD4_MIN = 8'd240;
   localparam logic [7:0] BYTE_LEAD4_MAX = 8'd244;
   localparam logic [7:0] BYTE_LEAD_E0   = 8'd224;
   localparam logic [7:0] BYTE_LEAD_ED   = 8'd237;
   localparam logic [7:0] BYTE_LEAD_F0   = 8'd240;
   localparam logic [7:0] BYTE_LEAD_F4   = 8'd244;
   localparam logic [7:0] BYTE_CONT_A0   = 8'd160;
   localparam logic [7:0] BYTE_CONT_B0   = 8'd176;
   localparam logic [7:0] BYTE_CONT_90   = 8'd144;

   // code point constants
   localparam int         UNIT_W        = 21;
   localparam logic [20:0] CP_HIGH_SURR = 21'd55296;
   localparam logic [20:0] CP_LOW_SURR  = 21'd56320;
   localparam logic [20:0] CP_PLANE1    = 21'd65536;

   // job queue sizing
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // one queued job: the results caused by one request
   typedef struct packed {
      logic              unit_valid;
      logic              pair;
      logic [UNIT_W-1:0] unit_value;
      logic              status_valid;
      logic              status_ok;
   } job_type;

endpackage

[rtl/utf8_decoder_validator_unit.sv]
// ----------------------------------------------------------------------------
// utf8_decoder_validator_unit
// utf-8 stream decoder to utf-16 / utf-32 units with validation status
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  req_*     in         tdata[7:0] byte_value, tlast end_of_stream
//  rsp_*     out        tdata[20:0] unit_value, tdata[21] stream_ok,
//                       tuser result_kind, tlast last_result
//  csr_*     in         data[1:0] output_form
//
//  one request is taken per cycle while the job queue has room
//  each request yields zero to three results, sent one per cycle by the
//  result sequencer while rsp_tready is high, so a supplementary character
//  with end mark makes three; the four-entry job queue absorbs such bursts
//  reset is synchronous, clears sequence state and queue, output_form to 0
//  rsp stalls back up through the queue to req_tready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_decoder_validator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] byte_value
   input  logic        req_tlast,    // end_of_stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // [20:0] unit_value, [21] stream_ok
   output logic        rsp_tlast,    // last_result
   output logic        rsp_tuser,    // result_kind
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_data      // [1:0] output_form
);

   logic [1:0]          form_ff;
   logic                queue_full;
   logic                push_valid;
   utf8dv_pkg::job_type push_job;
   logic                job_pop;
   logic                job_avail;
   utf8dv_pkg::job_type head_job;

   // output form register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         form_ff <= utf8dv_pkg::FORM_UTF16;
      end else if (csr_valid && csr_ready) begin
         form_ff <= csr_data;
      end
   end

   utf8dv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .form       (form_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   utf8dv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (job_pop),
      .avail      (job_avail),
      .head_job   (head_job)
   );

   utf8dv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_avail  (job_avail),
      .job        (head_job),
      .job_pop    (job_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[rtl/utf8dv_front.sv]
// ----------------------------------------------------------------------------
// utf8dv_front
// accepts bytes, tracks the partial sequence and queues result jobs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8dv_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           form,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] byte_value
   input  logic                 req_tlast,   // end_of_stream
   input  logic                 queue_full,
   output logic                 push_valid,
   output utf8dv_pkg::job_type  push_job
);

   logic [7:0]  lead_ff, lead_in;
   logic [1:0]  left_ff, left_in;
   logic [20:0] part_ff, part_in;
   logic        lsd_ff, lsd_in;
   logic        err_ff, err_in;

   logic        accept;
   logic        emit;
   logic        emit_four;
   logic [20:0] emit_value;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   // decode one byte against the held sequence
   always_comb begin
      logic [7:0]  b;
      logic        second;
      logic        bad;
      logic [20:0] shifted;
      b         = req_tdata;
      second    = 1'b0;
      bad       = 1'b0;
      shifted   = {part_ff[14:0], b[5:0]};
      lead_in   = lead_ff;
      left_in   = left_ff;
      part_in   = part_ff;
      lsd_in    = lsd_ff;
      err_in    = err_ff;
      emit      = 1'b0;
      emit_four = 1'b0;
      emit_value = '0;
      if (!err_ff) begin
         if (left_ff == 2'd0) begin
            if (lsd_ff && b != utf8dv_pkg::BYTE_LEAD_ED) begin
               err_in = 1'b1;
            end else if (b < utf8dv_pkg::BYTE_ASCII_END) begin
               emit       = 1'b1;
               emit_value = {13'd0, b};
            end else if (b < utf8dv_pkg::BYTE_LEAD2_MIN || b > utf8dv_pkg::BYTE_LEAD4_MAX) begin
               err_in = 1'b1;
            end else begin
               lead_in = b;
               if (b < utf8dv_pkg::BYTE_LEAD3_MIN) begin
                  left_in = 2'd1;
                  part_in = {16'd0, b[4:0]};
               end else if (b < utf8dv_pkg::BYTE_LEAD4_MIN) begin
                  left_in = 2'd2;
                  part_in = {17'd0, b[3:0]};
               end else begin
                  left_in = 2'd3;
                  part_in = {18'd0, b[2:0]};
               end
            end
         end else if (b < utf8dv_pkg::BYTE_ASCII_END || b > utf8dv_pkg::BYTE_CONT_LAST) begin
            err_in = 1'b1;
         end else begin
            // extra range checks on the second byte
            second = (lead_ff >= utf8dv_pkg::BYTE_LEAD3_MIN &&
                      lead_ff < utf8dv_pkg::BYTE_LEAD4_MIN && left_ff == 2'd2) ||
                     (lead_ff >= utf8dv_pkg::BYTE_LEAD4_MIN && left_ff == 2'd3);
            if (second) begin
               if (lead_ff == utf8dv_pkg::BYTE_LEAD_E0 && b < utf8dv_pkg::BYTE_CONT_A0)
                  bad = 1'b1;
               if (lead_ff == utf8dv_pkg::BYTE_LEAD_ED)
                  bad = lsd_ff ? (b < utf8dv_pkg::BYTE_CONT_B0)
                               : (b >= utf8dv_pkg::BYTE_CONT_B0);
               if (lead_ff == utf8dv_pkg::BYTE_LEAD_F0 && b < utf8dv_pkg::BYTE_CONT_90)
                  bad = 1'b1;
               if (lead_ff == utf8dv_pkg::BYTE_LEAD_F4 && b >= utf8dv_pkg::BYTE_CONT_90)
                  bad = 1'b1;
            end
            if (bad) begin
               err_in = 1'b1;
            end else begin
               part_in = shifted;
               left_in = left_ff - 2'd1;
               if (left_ff == 2'd1) begin
                  emit       = 1'b1;
                  emit_value = shifted;
                  if (lead_ff >= utf8dv_pkg::BYTE_LEAD4_MIN) begin
                     emit_four = 1'b1;
                  end else if (lead_ff == utf8dv_pkg::BYTE_LEAD_ED) begin
                     if (lsd_ff)
                        lsd_in = 1'b0;
                     else if (shifted >= utf8dv_pkg::CP_HIGH_SURR &&
                              shifted < utf8dv_pkg::CP_LOW_SURR)
                        lsd_in = 1'b1;
                  end
               end
            end
         end
      end
   end

   // build the job for this request
   always_comb begin
      push_job              = '0;
      push_job.unit_value   = emit_value;
      push_job.unit_valid   = emit && (form == utf8dv_pkg::FORM_UTF16 ||
                                       form == utf8dv_pkg::FORM_UTF32);
      push_job.pair         = emit && emit_four && form == utf8dv_pkg::FORM_UTF16;
      push_job.status_valid = req_tlast;
      push_job.status_ok    = !err_in && left_in == 2'd0 && !lsd_in;
      push_valid = accept && (push_job.unit_valid || push_job.status_valid);
   end

   // sequence state, cleared at end of stream
   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff <= '0;
         left_ff <= '0;
         part_ff <= '0;
         lsd_ff  <= 1'b0;
         err_ff  <= 1'b0;
      end else if (accept) begin
         if (req_tlast) begin
            lead_ff <= '0;
            left_ff <= '0;
            part_ff <= '0;
            lsd_ff  <= 1'b0;
            err_ff  <= 1'b0;
         end else begin
            lead_ff <= lead_in;
            left_ff <= left_in;
            part_ff <= part_in;
            lsd_ff  <= lsd_in;
            err_ff  <= err_in;
         end
      end
   end

endmodule

[rtl/utf8dv_queue.sv]
// ----------------------------------------------------------------------------
// utf8dv_queue
// short job queue between the byte front end and the result sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8dv_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  utf8dv_pkg::job_type  push_job,
   output logic                 full,
   input  logic                 pop,
   output logic                 avail,
   output utf8dv_pkg::job_type  head_job
);

   localparam int AW = utf8dv_pkg::QUEUE_AW;
   localparam int CW = utf8dv_pkg::QUEUE_CW;

   utf8dv_pkg::job_type slot_ff [utf8dv_pkg::QUEUE_DEPTH];
   logic [AW-1:0] wr_ff, wr_in;
   logic [AW-1:0] rd_ff, rd_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   assign full     = count_ff == CW'(utf8dv_pkg::QUEUE_DEPTH);
   assign avail    = count_ff != '0;
   assign head_job = slot_ff[rd_ff];
   assign do_push  = push_valid && !full;
   assign do_pop   = pop && avail;

   // pointer and count update
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push)
         wr_in = (wr_ff == AW'(utf8dv_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (do_pop)
         rd_in = (rd_ff == AW'(utf8dv_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (do_push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (!do_push && do_pop)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (do_push)
         slot_ff[wr_ff] <= push_job;
   end

endmodule

[rtl/utf8dv_back.sv]
// ----------------------------------------------------------------------------
// utf8dv_back
// expands queued jobs into one result per cycle, unless rsp stalls, behind an output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "utf8_decoder_validator_unit_assert.svh"

module utf8dv_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_avail,
   input  utf8dv_pkg::job_type  job,
   output logic                 job_pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [23:0]          rsp_tdata,   // [20:0] unit_value, [21] stream_ok
   output logic                 rsp_tlast,   // last_result
   output logic                 rsp_tuser    // result_kind
);

   logic [1:0]  phase_ff, phase_in;
   logic        valid_ff, valid_in;
   logic [20:0] unit_ff, unit_in;
   logic        ok_ff, ok_in;
   logic        kind_ff, kind_in;
   logic        last_ff, last_in;

   logic        load;
   logic [1:0]  n_units;
   logic [1:0]  n_total;
   logic [20:0] offset;
   logic [20:0] hi_unit;
   logic [20:0] lo_unit;

   assign load = !valid_ff || rsp_tready;

   // surrogate split of a supplementary code point
   assign offset  = job.unit_value - utf8dv_pkg::CP_PLANE1;
   assign hi_unit = {11'd0, offset[19:10]} + utf8dv_pkg::CP_HIGH_SURR;
   assign lo_unit = {11'd0, offset[9:0]} + utf8dv_pkg::CP_LOW_SURR;

   assign n_units = job.pair ? 2'd2 : {1'b0, job.unit_valid};
   assign n_total = n_units + {1'b0, job.status_valid};

   // pick the result for the current phase of the head job
   always_comb begin
      phase_in = phase_ff;
      valid_in = valid_ff;
      unit_in  = unit_ff;
      ok_in    = ok_ff;
      kind_in  = kind_ff;
      last_in  = last_ff;
      job_pop  = 1'b0;
      if (load) begin
         valid_in = job_avail;
         if (job_avail) begin
            if (phase_ff < n_units) begin
               kind_in = 1'b0;
               ok_in   = 1'b0;
               if (job.pair)
                  unit_in = (phase_ff == 2'd0) ? hi_unit : lo_unit;
               else
                  unit_in = job.unit_value;
            end else begin
               kind_in = 1'b1;
               ok_in   = job.status_ok;
               unit_in = '0;
            end
            last_in = phase_ff == (n_total - 2'd1);
            if (last_in) begin
               job_pop  = 1'b1;
               phase_in = 2'd0;
            end else begin
               phase_in = phase_ff + 2'd1;
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      unit_ff <= unit_in;
      ok_ff   <= ok_in;
      kind_ff <= kind_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {2'd0, ok_ff, unit_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = kind_ff;

   // checks
   `UDV_ASSERT_NOW(a_status_is_last, clock, reset, valid_ff && kind_ff, last_ff)
   `UDV_ASSERT_NOW(a_unit_not_ok, clock, reset, valid_ff && !kind_ff, !ok_ff)
   `UDV_ASSERT_NOW(a_phase_range, clock, reset, 1'b1, phase_ff != 2'd3)
   `UDV_ASSERT_NOW(a_pop_needs_job, clock, reset, job_pop, job_avail)
   `UDV_ASSERT_NEXT(a_fill_empty_reg, clock, reset, !valid_ff && job_avail, valid_ff)

endmodule
